// ----- hdl/associative_memory_write_random_replace_top_defines.svh -----
// ----------------------------------------------------------------------------
// Associative memory write: assertion macros
// Shared assertion forms, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSOCIATIVE_MEMORY_WRITE_RANDOM_REPLACE_TOP_DEFINES_SVH
`define ASSOCIATIVE_MEMORY_WRITE_RANDOM_REPLACE_TOP_DEFINES_SVH

// Same-cycle implication.
`define AMWRR_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define AMWRR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/amwrr_pkg.sv -----
// ----------------------------------------------------------------------------
// Associative memory write package
// Sizes, field widths, register indexes and the types shared by the modules.
// ----------------------------------------------------------------------------
package amwrr_pkg;

   localparam int NEURONS      = 256;
   localparam int DEPTH        = 64;
   localparam int PATTERN_BITS = 64;
   localparam int VALUE_BITS   = 32;

   localparam int NEURON_FIELD_W  = 8;
   localparam int PATTERN_FIELD_W = 64;
   localparam int VALUE_FIELD_W   = 32;
   localparam int KIND_W          = 2;
   localparam int SLOT_FIELD_W    = 6;
   localparam int CSR_DATA_W      = 7;
   localparam int CSR_INDEX_W     = 2;

   localparam int NEURON_W = (NEURONS > 1) ? $clog2(NEURONS) : 1;
   localparam int SLOT_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ENT_W    = $clog2(DEPTH + 1);
   localparam int ADDR_W   = NEURON_W + SLOT_W;
   localparam int WORDS    = NEURONS * (1 << SLOT_W);

   localparam int                 LFSR_BITS   = 16;
   localparam int                 LFSR_CNT_W  = $clog2(LFSR_BITS);
   localparam logic [LFSR_BITS-1:0] LFSR_TAPS = 16'hB400;
   localparam logic [LFSR_BITS-1:0] LFSR_SEED = 16'h0001;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRIES_IN_USE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_BITS_USED = 2'd1;

   localparam logic [CSR_DATA_W-1:0] ENTRIES_RESET      = 7'd64;
   localparam logic [CSR_DATA_W-1:0] PATTERN_BITS_RESET = 7'd64;

   typedef enum logic [KIND_W-1:0] {
      KIND_MATCH   = 2'd0,
      KIND_FILL    = 2'd1,
      KIND_REPLACE = 2'd2
   } write_kind_type;

   typedef struct packed {
      logic [NEURON_W-1:0]     neuron;
      logic [PATTERN_BITS-1:0] pattern;
      logic [VALUE_BITS-1:0]   value;
      logic [PATTERN_BITS-1:0] cmask;
      logic [ENT_W-1:0]        entries;
   } item_type;

endpackage

// ----- hdl/amwrr_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module amwrr_ram #(
   parameter int WIDTH       = 8,
   parameter int DEPTH_WORDS = 16
) (
   input  logic                           clock,
   input  logic                           we,
   input  logic [$clog2(DEPTH_WORDS)-1:0] waddr,
   input  logic [WIDTH-1:0]               wdata,
   input  logic [$clog2(DEPTH_WORDS)-1:0] raddr,
   output logic [WIDTH-1:0]               rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH_WORDS];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/amwrr_front.sv -----
// ----------------------------------------------------------------------------
// Associative memory write front end
// Holds the configuration registers, takes in request beats and turns them
// into work items with the neuron, compare mask and entry count resolved.
// ----------------------------------------------------------------------------
module amwrr_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [amwrr_pkg::NEURON_FIELD_W-1:0] req_neuron_index,
   input  logic [amwrr_pkg::PATTERN_FIELD_W-1:0] req_pattern,
   input  logic signed [amwrr_pkg::VALUE_FIELD_W-1:0] req_associated_value,
   input  logic                                 csr_we,
   input  logic [amwrr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [amwrr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                                 push,
   output amwrr_pkg::item_type                  push_item,
   input  logic                                 queue_full
);

   logic [amwrr_pkg::CSR_DATA_W-1:0]   entries_ff;
   logic [amwrr_pkg::CSR_DATA_W-1:0]   entries_in;
   logic [amwrr_pkg::CSR_DATA_W-1:0]   pbits_ff;
   logic [amwrr_pkg::CSR_DATA_W-1:0]   pbits_in;
   logic                               valid_ff;
   logic                               valid_in;
   amwrr_pkg::item_type                item_ff;
   amwrr_pkg::item_type                item_in;
   logic                               accept;
   logic [amwrr_pkg::CSR_DATA_W-1:0]   cmp_bits;
   logic [amwrr_pkg::ENT_W-1:0]        ent;

   assign accept = start && !valid_ff;
   assign busy   = valid_ff;
   assign push   = valid_ff && !queue_full;
   assign push_item = item_ff;

   always_comb begin
      entries_in = entries_ff;
      pbits_in   = pbits_ff;
      if (csr_we) begin
         unique case (csr_index)
            amwrr_pkg::CSR_ENTRIES_IN_USE:    entries_in = csr_wdata;
            amwrr_pkg::CSR_PATTERN_BITS_USED: pbits_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (pbits_ff > amwrr_pkg::CSR_DATA_W'(amwrr_pkg::PATTERN_BITS)) begin
         cmp_bits = amwrr_pkg::CSR_DATA_W'(amwrr_pkg::PATTERN_BITS);
      end else begin
         cmp_bits = pbits_ff;
      end
      if (entries_ff == '0) begin
         ent = amwrr_pkg::ENT_W'(1);
      end else if (entries_ff > amwrr_pkg::CSR_DATA_W'(amwrr_pkg::DEPTH)) begin
         ent = amwrr_pkg::ENT_W'(amwrr_pkg::DEPTH);
      end else begin
         ent = amwrr_pkg::ENT_W'(entries_ff);
      end
   end

   always_comb begin
      item_in = item_ff;
      if (accept) begin
         item_in.neuron  = req_neuron_index[amwrr_pkg::NEURON_W-1:0];
         item_in.pattern = req_pattern[amwrr_pkg::PATTERN_BITS-1:0];
         item_in.value   = req_associated_value[amwrr_pkg::VALUE_BITS-1:0];
         item_in.entries = ent;
         if (cmp_bits >= amwrr_pkg::CSR_DATA_W'(amwrr_pkg::PATTERN_BITS)) begin
            item_in.cmask = '1;
         end else begin
            item_in.cmask = (amwrr_pkg::PATTERN_BITS'(1) << cmp_bits) -
                            amwrr_pkg::PATTERN_BITS'(1);
         end
      end
      if (valid_ff) begin
         valid_in = !push;
      end else begin
         valid_in = accept;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= amwrr_pkg::ENTRIES_RESET;
         pbits_ff   <= amwrr_pkg::PATTERN_BITS_RESET;
         valid_ff   <= 1'b0;
      end else begin
         entries_ff <= entries_in;
         pbits_ff   <= pbits_in;
         valid_ff   <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

// ----- hdl/amwrr_queue.sv -----
// ----------------------------------------------------------------------------
// Associative memory write work queue
// Short first-in first-out buffer of work items between front and back end.
// ----------------------------------------------------------------------------
module amwrr_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  amwrr_pkg::item_type push_item,
   output logic                full,
   input  logic                pop,
   output amwrr_pkg::item_type head,
   output logic                empty
);

   amwrr_pkg::item_type                  slots_ff [amwrr_pkg::QUEUE_DEPTH];
   logic [amwrr_pkg::QPTR_W-1:0]         wr_ptr_ff;
   logic [amwrr_pkg::QPTR_W-1:0]         wr_ptr_in;
   logic [amwrr_pkg::QPTR_W-1:0]         rd_ptr_ff;
   logic [amwrr_pkg::QPTR_W-1:0]         rd_ptr_in;
   logic [amwrr_pkg::QPTR_W:0]           count_ff;
   logic [amwrr_pkg::QPTR_W:0]           count_in;

   assign full  = (count_ff == (amwrr_pkg::QPTR_W + 1)'(amwrr_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + amwrr_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + amwrr_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (amwrr_pkg::QPTR_W + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (amwrr_pkg::QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- hdl/amwrr_back.sv -----
// ----------------------------------------------------------------------------
// Associative memory write back end
// Searches one neuron's entries, writes the value or pattern and value, keeps
// the fill counts and the replacement LFSR, and issues the result beat.
// ----------------------------------------------------------------------------
module amwrr_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              queue_empty,
   input  amwrr_pkg::item_type               queue_head,
   output logic                              pop,
   output logic                              rsp_valid,
   output logic [amwrr_pkg::KIND_W-1:0]      rsp_write_kind,
   output logic [amwrr_pkg::SLOT_FIELD_W-1:0] rsp_slot
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FCNT,
      ST_SEARCH,
      ST_MOD
   } state_type;

   state_type                          state_ff;
   state_type                          state_in;
   amwrr_pkg::item_type                item_ff;
   amwrr_pkg::item_type                item_in;
   logic [amwrr_pkg::ENT_W-1:0]        filled_ff;
   logic [amwrr_pkg::ENT_W-1:0]        filled_in;
   logic [amwrr_pkg::SLOT_W-1:0]       idx_ff;
   logic [amwrr_pkg::SLOT_W-1:0]       idx_in;
   logic [amwrr_pkg::LFSR_BITS-1:0]    lfsr_ff;
   logic [amwrr_pkg::LFSR_BITS-1:0]    lfsr_in;
   logic [amwrr_pkg::ENT_W-1:0]        rem_ff;
   logic [amwrr_pkg::ENT_W-1:0]        rem_in;
   logic [amwrr_pkg::LFSR_CNT_W-1:0]   step_ff;
   logic [amwrr_pkg::LFSR_CNT_W-1:0]   step_in;
   logic [amwrr_pkg::NEURONS-1:0]      fvalid_ff;
   logic [amwrr_pkg::NEURONS-1:0]      fvalid_in;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   amwrr_pkg::write_kind_type          rsp_kind_ff;
   amwrr_pkg::write_kind_type          rsp_kind_in;
   logic [amwrr_pkg::SLOT_W-1:0]       rsp_slot_ff;
   logic [amwrr_pkg::SLOT_W-1:0]       rsp_slot_in;

   logic [amwrr_pkg::ENT_W-1:0]        fcnt_rdata;
   logic                               fcnt_we;
   logic [amwrr_pkg::ENT_W-1:0]        fcnt_wdata;
   logic [amwrr_pkg::PATTERN_BITS-1:0] pat_rdata;
   logic                               pat_we;
   logic                               val_we;
   logic [amwrr_pkg::SLOT_W-1:0]       wr_slot;
   logic [amwrr_pkg::SLOT_W-1:0]       rd_slot;
   logic [amwrr_pkg::ENT_W-1:0]        fill_raw;
   logic [amwrr_pkg::ENT_W-1:0]        fill_clamped;
   logic [amwrr_pkg::ENT_W-1:0]        miss_filled;
   logic                               miss;
   logic                               hit;
   logic                               lfsr_bit;
   logic [amwrr_pkg::ENT_W:0]          rem_trial;

   assign fill_raw = fvalid_ff[item_ff.neuron] ? fcnt_rdata : '0;
   assign fill_clamped = (fill_raw > item_ff.entries) ? item_ff.entries : fill_raw;
   assign hit = (((pat_rdata ^ item_ff.pattern) & item_ff.cmask) == '0);
   assign rd_slot = (state_ff == ST_SEARCH) ? idx_ff + amwrr_pkg::SLOT_W'(1) : '0;
   assign lfsr_bit = lfsr_ff[amwrr_pkg::LFSR_CNT_W'(amwrr_pkg::LFSR_BITS - 1) - step_ff];
   assign rem_trial = {rem_ff, lfsr_bit};

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      filled_in    = filled_ff;
      idx_in       = idx_ff;
      lfsr_in      = lfsr_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      fvalid_in    = fvalid_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_slot_in  = rsp_slot_ff;
      pop          = 1'b0;
      fcnt_we      = 1'b0;
      fcnt_wdata   = '0;
      pat_we       = 1'b0;
      val_we       = 1'b0;
      wr_slot      = '0;
      miss         = 1'b0;
      miss_filled  = filled_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               item_in  = queue_head;
               state_in = ST_FCNT;
            end
         end
         ST_FCNT: begin
            filled_in = fill_clamped;
            idx_in    = '0;
            if (fill_clamped == '0) begin
               miss        = 1'b1;
               miss_filled = fill_clamped;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (hit) begin
               val_we       = 1'b1;
               wr_slot      = idx_ff;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = amwrr_pkg::KIND_MATCH;
               rsp_slot_in  = idx_ff;
               state_in     = ST_IDLE;
            end else if (amwrr_pkg::ENT_W'(idx_ff) + amwrr_pkg::ENT_W'(1) == filled_ff) begin
               miss        = 1'b1;
               miss_filled = filled_ff;
            end else begin
               idx_in = idx_ff + amwrr_pkg::SLOT_W'(1);
            end
         end
         ST_MOD: begin
            if (rem_trial >= {1'b0, item_ff.entries}) begin
               rem_in = amwrr_pkg::ENT_W'(rem_trial - {1'b0, item_ff.entries});
            end else begin
               rem_in = amwrr_pkg::ENT_W'(rem_trial);
            end
            if (step_ff == amwrr_pkg::LFSR_CNT_W'(amwrr_pkg::LFSR_BITS - 1)) begin
               pat_we       = 1'b1;
               val_we       = 1'b1;
               wr_slot      = rem_in[amwrr_pkg::SLOT_W-1:0];
               rsp_valid_in = 1'b1;
               rsp_kind_in  = amwrr_pkg::KIND_REPLACE;
               rsp_slot_in  = rem_in[amwrr_pkg::SLOT_W-1:0];
               state_in     = ST_IDLE;
            end else begin
               step_in = step_ff + amwrr_pkg::LFSR_CNT_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (miss) begin
         if (miss_filled < item_ff.entries) begin
            pat_we                     = 1'b1;
            val_we                     = 1'b1;
            wr_slot                    = miss_filled[amwrr_pkg::SLOT_W-1:0];
            fcnt_we                    = 1'b1;
            fcnt_wdata                 = miss_filled + amwrr_pkg::ENT_W'(1);
            fvalid_in[item_ff.neuron]  = 1'b1;
            rsp_valid_in               = 1'b1;
            rsp_kind_in                = amwrr_pkg::KIND_FILL;
            rsp_slot_in                = miss_filled[amwrr_pkg::SLOT_W-1:0];
            state_in                   = ST_IDLE;
         end else begin
            lfsr_in = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? amwrr_pkg::LFSR_TAPS : '0);
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_MOD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lfsr_ff      <= amwrr_pkg::LFSR_SEED;
         fvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lfsr_ff      <= lfsr_in;
         fvalid_ff    <= fvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      filled_ff   <= filled_in;
      idx_ff      <= idx_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_slot_ff <= rsp_slot_in;
   end

   amwrr_ram #(
      .WIDTH       (amwrr_pkg::ENT_W),
      .DEPTH_WORDS (amwrr_pkg::NEURONS)
   ) u_fcnt_ram (
      .clock (clock),
      .we    (fcnt_we),
      .waddr (item_ff.neuron),
      .wdata (fcnt_wdata),
      .raddr (queue_head.neuron),
      .rdata (fcnt_rdata)
   );

   amwrr_ram #(
      .WIDTH       (amwrr_pkg::PATTERN_BITS),
      .DEPTH_WORDS (amwrr_pkg::WORDS)
   ) u_pattern_ram (
      .clock (clock),
      .we    (pat_we),
      .waddr ({item_ff.neuron, wr_slot}),
      .wdata (item_ff.pattern),
      .raddr ({item_ff.neuron, rd_slot}),
      .rdata (pat_rdata)
   );

   amwrr_ram #(
      .WIDTH       (amwrr_pkg::VALUE_BITS),
      .DEPTH_WORDS (amwrr_pkg::WORDS)
   ) u_value_ram (
      .clock (clock),
      .we    (val_we),
      .waddr ({item_ff.neuron, wr_slot}),
      .wdata (item_ff.value),
      .raddr ('0),
      .rdata ()
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_write_kind = rsp_kind_ff;
   assign rsp_slot       = amwrr_pkg::SLOT_FIELD_W'(rsp_slot_ff);

endmodule

// ----- hdl/associative_memory_write_random_replace_top.sv -----
// ----------------------------------------------------------------------------
// Associative memory write with random replacement
// Trains the per-neuron associative memories of a weightless neural layer.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low; it names a
// neuron, a pattern and a value. The front end holds one beat and passes it
// to a two-entry queue, so up to three requests wait while the back end works.
// The back end reads the neuron's fill count, then compares one stored entry
// per cycle from the pattern memory port. For every request exactly one
// result beat appears on rsp_valid, rsp_write_kind and rsp_slot for a single
// cycle; the receiver cannot stall it.
// A replacement uses a 16-step remainder unit that picks the slot from the
// LFSR. The back end takes the next request from the queue only once the
// current one has produced its result beat. Configuration writes on csr_we,
// csr_index and csr_wdata apply to request beats accepted after the write.
// They must be made only while the block is idle; the block itself does
// not enforce this. Reset empties every neuron's memory, reloads both
// registers with 64 and seeds the LFSR with one.
// ----------------------------------------------------------------------------
`include "associative_memory_write_random_replace_top_defines.svh"

module associative_memory_write_random_replace_top (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   output logic                                       busy,
   input  logic [amwrr_pkg::NEURON_FIELD_W-1:0]       req_neuron_index,
   input  logic [amwrr_pkg::PATTERN_FIELD_W-1:0]      req_pattern,
   input  logic signed [amwrr_pkg::VALUE_FIELD_W-1:0] req_associated_value,
   output logic                                       rsp_valid,
   output logic [amwrr_pkg::KIND_W-1:0]               rsp_write_kind,
   output logic [amwrr_pkg::SLOT_FIELD_W-1:0]         rsp_slot,
   input  logic                                       csr_we,
   input  logic [amwrr_pkg::CSR_INDEX_W-1:0]          csr_index,
   input  logic [amwrr_pkg::CSR_DATA_W-1:0]           csr_wdata
);

   logic                push;
   amwrr_pkg::item_type push_item;
   logic                queue_full;
   logic                pop;
   amwrr_pkg::item_type queue_head;
   logic                queue_empty;

   amwrr_front u_front (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_neuron_index     (req_neuron_index),
      .req_pattern          (req_pattern),
      .req_associated_value (req_associated_value),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .push                 (push),
      .push_item            (push_item),
      .queue_full           (queue_full)
   );

   amwrr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .head      (queue_head),
      .empty     (queue_empty)
   );

   amwrr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (queue_empty),
      .queue_head     (queue_head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_write_kind (rsp_write_kind),
      .rsp_slot       (rsp_slot)
   );

   `AMWRR_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy, "accepted beat did not set busy")
   `AMWRR_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid, "result beats in consecutive cycles")
   `AMWRR_ASSERT_IMPL(a_busy_from_start, $rose(busy), $past(start), "busy rose without a request")

endmodule

// ----- tb/associative_memory_write_random_replace_top_test.sv -----
// ----------------------------------------------------------------------------
// Associative memory write with random replacement: block-level test
// Drives request beats and register writes into the block and predicts each
// write kind and slot from its own copy of every neuron's fill count, the
// stored patterns and the replacement LFSR. A short directed run covers the
// field extremes and the corner cases of the registers. Random phases then
// follow under several register settings and sender idle rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module associative_memory_write_random_replace_top_test;
   import amwrr_pkg::*;

   typedef struct packed {
      write_kind_type              kind;
      logic [SLOT_FIELD_W-1:0]     slot;
   } slot_write_t;

   class write_scoreboard;
      logic [PATTERN_BITS-1:0] pattern_mem [NEURONS*DEPTH];
      int unsigned             fill_cnt [NEURONS];
      logic [LFSR_BITS-1:0]    lfsr;
      int unsigned             entries_reg;
      int unsigned             pbits_reg;
      slot_write_t             expected_writes [$];
      int unsigned             errors;

      function new();
         foreach (fill_cnt[i]) fill_cnt[i] = 0;
         lfsr        = LFSR_SEED;
         entries_reg = 32'(ENTRIES_RESET);
         pbits_reg   = 32'(PATTERN_BITS_RESET);
         errors      = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == CSR_ENTRIES_IN_USE)
            entries_reg = 32'(val);
         else if (idx == CSR_PATTERN_BITS_USED)
            pbits_reg = 32'(val);
      endfunction

      function int unsigned pending();
         return expected_writes.size();
      endfunction

      function void note_request(logic [NEURON_FIELD_W-1:0] neuron,
                                 logic [PATTERN_FIELD_W-1:0] pattern);
         int unsigned             n;
         int unsigned             ent;
         int unsigned             bits;
         int unsigned             filled;
         int unsigned             base;
         int unsigned             j;
         logic [PATTERN_BITS-1:0] cmask;
         slot_write_t             e;
         n    = neuron % NEURONS;
         ent  = (entries_reg == 0) ? 1 : ((entries_reg > DEPTH) ? DEPTH : entries_reg);
         bits = (pbits_reg > PATTERN_BITS) ? PATTERN_BITS : pbits_reg;
         cmask = (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
         filled = (fill_cnt[n] > ent) ? ent : fill_cnt[n];
         base = n * DEPTH;
         j = 0;
         while (j < filled && ((pattern_mem[base+j] ^ pattern) & cmask) != '0)
            j++;
         if (j < filled) begin
            e.kind = KIND_MATCH;
         end else if (filled < ent) begin
            j = filled;
            fill_cnt[n] = filled + 1;
            pattern_mem[base+j] = pattern;
            e.kind = KIND_FILL;
         end else begin
            lfsr = {1'b0, lfsr[LFSR_BITS-1:1]} ^ (lfsr[0] ? LFSR_TAPS : '0);
            j = lfsr % ent;
            pattern_mem[base+j] = pattern;
            e.kind = KIND_REPLACE;
         end
         e.slot = j[SLOT_FIELD_W-1:0];
         expected_writes.push_back(e);
      endfunction

      function void check_result(logic [KIND_W-1:0] kind, logic [SLOT_FIELD_W-1:0] slot);
         slot_write_t e;
         if (expected_writes.size() == 0) begin
            $error("unexpected result beat: write_kind %0d, slot %0d", kind, slot);
            errors++;
            return;
         end
         e = expected_writes.pop_front();
         if (kind !== e.kind) begin
            $error("write_kind: expected %0d, actual %0d", e.kind, kind);
            errors++;
         end
         if (slot !== e.slot) begin
            $error("slot: expected %0d, actual %0d", e.slot, slot);
            errors++;
         end
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              start = 1'b0;
   logic                              busy;
   logic [NEURON_FIELD_W-1:0]         req_neuron_index = '0;
   logic [PATTERN_FIELD_W-1:0]        req_pattern = '0;
   logic signed [VALUE_FIELD_W-1:0]   req_associated_value = '0;
   logic                              rsp_valid;
   logic [KIND_W-1:0]                 rsp_write_kind;
   logic [SLOT_FIELD_W-1:0]           rsp_slot;
   logic                              csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]            csr_index = '0;
   logic [CSR_DATA_W-1:0]             csr_wdata = '0;

   write_scoreboard board = new();
   int unsigned     idle_pct = 0;

   associative_memory_write_random_replace_top dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_neuron_index     (req_neuron_index),
      .req_pattern          (req_pattern),
      .req_associated_value (req_associated_value),
      .rsp_valid            (rsp_valid),
      .rsp_write_kind       (rsp_write_kind),
      .rsp_slot             (rsp_slot),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         board.check_result(rsp_write_kind, rsp_slot);
   end

   task automatic send_item(input logic [NEURON_FIELD_W-1:0] neuron,
                            input logic [PATTERN_FIELD_W-1:0] pattern,
                            input logic [VALUE_FIELD_W-1:0] value);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start                <= 1'b1;
      req_neuron_index     <= neuron;
      req_pattern          <= pattern;
      req_associated_value <= value;
      do
         @(posedge clock);
      while (!(start && !busy));
      board.note_request(neuron, pattern);
   endtask

   // Lets every outstanding beat drain so that registers change only while idle.
   task automatic drain();
      start <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   task automatic set_regs(input logic [CSR_DATA_W-1:0] entries,
                           input logic [CSR_DATA_W-1:0] pbits);
      drain();
      csr_we    <= 1'b1;
      csr_index <= CSR_ENTRIES_IN_USE;
      csr_wdata <= entries;
      @(posedge clock);
      board.write_reg(CSR_ENTRIES_IN_USE, entries);
      csr_index <= CSR_PATTERN_BITS_USED;
      csr_wdata <= pbits;
      @(posedge clock);
      board.write_reg(CSR_PATTERN_BITS_USED, pbits);
      csr_we <= 1'b0;
   endtask

   // Most beats target a few busy neurons and reuse a small set of patterns,
   // often with noise above the compared bits, so that matches, fills and
   // replacements all occur.
   task automatic run_random(input int unsigned count, input int unsigned pbits);
      logic [PATTERN_BITS-1:0]   pool [8];
      logic [NEURON_FIELD_W-1:0] hot [4];
      logic [PATTERN_BITS-1:0]   noise_mask;
      logic [PATTERN_BITS-1:0]   pat;
      logic [NEURON_FIELD_W-1:0] neuron;
      int unsigned               sel;
      foreach (pool[i]) pool[i] = {$urandom, $urandom};
      foreach (hot[i]) hot[i] = NEURON_FIELD_W'($urandom);
      noise_mask = (pbits >= 64) ? '0 : ~((64'd1 << pbits) - 64'd1);
      repeat (count) begin
         neuron = ($urandom_range(99) < 85) ? hot[$urandom_range(3)] :
                                              NEURON_FIELD_W'($urandom);
         sel = $urandom_range(99);
         pat = pool[$urandom_range(7)];
         if (sel < 40)
            pat = pat ^ ({$urandom, $urandom} & noise_mask);
         else if (sel >= 80)
            pat = {$urandom, $urandom};
         send_item(neuron, pat, $urandom);
      end
   endtask

   initial begin
      int unsigned entries_list [8] = '{3, 64, 1, 8, 127, 2, 0, 5};
      int unsigned pbits_list [8]   = '{64, 8, 127, 1, 0, 63, 16, 4};
      int unsigned idle_list [4]    = '{0, 59, 0, 35};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: fills and exact matches, extremes of every field.
      send_item(8'd0, 64'd0, 32'h8000_0000);
      send_item(8'd0, '1, 32'h7FFF_FFFF);
      send_item(8'd0, 64'd0, 32'd0);
      send_item(8'd255, '1, 32'hFFFF_FFFF);
      send_item(8'd255, 64'h8000_0000_0000_0000, 32'd1);
      send_item(8'd255, 64'd1, 32'd2);
      send_item(8'd255, '1, 32'd3);

      // Two entries: neuron 255 holds three, so its count exceeds the limit.
      set_regs(7'd2, 7'd64);
      send_item(8'd0, 64'h1234, 32'd4);
      send_item(8'd255, 64'h5678, 32'd5);
      send_item(8'd1, 64'hAAAA, 32'd6);
      send_item(8'd1, 64'h5555, 32'd7);
      send_item(8'd1, 64'hFFFF, 32'd8);

      // Entry count zero acts as one; no compared bits, so once slot 0 is filled every pattern matches it.
      set_regs(7'd0, 7'd0);
      send_item(8'd2, 64'hDEAD, 32'd9);
      send_item(8'd2, 64'hBEEF, 32'd10);
      send_item(8'd3, '1, 32'd11);

      // Oversized entry count, single compared bit.
      set_regs(7'd127, 7'd1);
      send_item(8'd4, 64'd0, 32'd12);
      send_item(8'd4, 64'd2, 32'd13);
      send_item(8'd4, 64'd1, 32'd14);

      foreach (entries_list[p]) begin
         set_regs(CSR_DATA_W'(entries_list[p]), CSR_DATA_W'(pbits_list[p]));
         idle_pct = idle_list[p % 4];
         run_random(235, (pbits_list[p] > 64) ? 64 : pbits_list[p]);
         idle_pct = 0;
      end

      drain();
      repeat (100) @(posedge clock);
      if (board.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #10ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
